/* rtl/r2fft_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared constants and twiddle table for the radix-2 FFT.
// ----------------------------------------------------------------------------
package r2fft_pkg;

    localparam int ROM_LOG2 = 6;

    localparam logic [0:0] REG_LOG2_POINTS  = 1'b0;
    localparam logic [0:0] REG_INVERSE_MODE = 1'b1;

    // sin(2*pi*k/64) * 32768, k = 0..16
    function automatic logic signed [16:0] quarter_sine(input logic [4:0] k);
        logic signed [16:0] v;
        unique case (k)
            5'd0:  v = 17'sd0;
            5'd1:  v = 17'sd3212;
            5'd2:  v = 17'sd6393;
            5'd3:  v = 17'sd9512;
            5'd4:  v = 17'sd12540;
            5'd5:  v = 17'sd15447;
            5'd6:  v = 17'sd18205;
            5'd7:  v = 17'sd20788;
            5'd8:  v = 17'sd23170;
            5'd9:  v = 17'sd25330;
            5'd10: v = 17'sd27246;
            5'd11: v = 17'sd28899;
            5'd12: v = 17'sd30274;
            5'd13: v = 17'sd31357;
            5'd14: v = 17'sd32138;
            5'd15: v = 17'sd32610;
            5'd16: v = 17'sd32768;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

endpackage : r2fft_pkg
`default_nettype wire

/* rtl/r2fft_bfly.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// r2fft_bfly
// Pipelined butterfly: twiddle lookup, four rounded products, saturating
// sum and difference. Three register stages from operands to results.
// ----------------------------------------------------------------------------
module r2fft_bfly
    import r2fft_pkg::*;
#(
    parameter int STORE_BITS = 24
) (
    input  wire                          aclk,
    input  wire  [4:0]                   twiddle_k,
    input  wire                          inverse,
    input  wire  signed [STORE_BITS-1:0] a_re,
    input  wire  signed [STORE_BITS-1:0] a_im,
    input  wire  signed [STORE_BITS-1:0] b_re,
    input  wire  signed [STORE_BITS-1:0] b_im,
    output logic signed [STORE_BITS-1:0] x_re,
    output logic signed [STORE_BITS-1:0] x_im,
    output logic signed [STORE_BITS-1:0] y_re,
    output logic signed [STORE_BITS-1:0] y_im
);
    localparam int PB = STORE_BITS + 17;
    localparam int SB = STORE_BITS + 2;

    logic signed [16:0] wr, ws, wi;
    logic signed [16:0] wr_reg, wi_reg;
    logic signed [STORE_BITS-1:0] a1re_reg, a1im_reg, b1re_reg, b1im_reg;
    logic signed [STORE_BITS-1:0] a2re_reg, a2im_reg;
    logic signed [PB-1:0] prr_reg, pii_reg, pri_reg, pir_reg;
    logic signed [PB-1:0] rrr, rii, rri, rir;
    logic signed [SB-1:0] tr, ti, sxr, sxi, syr, syi;

    function automatic logic signed [STORE_BITS-1:0] sat(input logic signed [SB-1:0] v);
        logic signed [SB-1:0] hi, lo;
        hi = SB'((SB'(1) <<< (STORE_BITS - 1)) - 1);
        lo = -hi - SB'(1);
        if (v > hi) return hi[STORE_BITS-1:0];
        else if (v < lo) return lo[STORE_BITS-1:0];
        else return v[STORE_BITS-1:0];
    endfunction

    always_comb begin
        if (twiddle_k <= 5'd16) begin
            wr = quarter_sine(5'(5'd16 - twiddle_k));
            ws = quarter_sine(twiddle_k);
        end else begin
            wr = -quarter_sine(5'(twiddle_k - 5'd16));
            ws = quarter_sine(5'(6'd32 - {1'b0, twiddle_k}));
        end
        wi = inverse ? ws : -ws;
    end

    always_ff @(posedge aclk) begin
        wr_reg   <= wr;
        wi_reg   <= wi;
        a1re_reg <= a_re;
        a1im_reg <= a_im;
        b1re_reg <= b_re;
        b1im_reg <= b_im;
        prr_reg  <= PB'(wr_reg) * PB'(b1re_reg);
        pii_reg  <= PB'(wi_reg) * PB'(b1im_reg);
        pri_reg  <= PB'(wr_reg) * PB'(b1im_reg);
        pir_reg  <= PB'(wi_reg) * PB'(b1re_reg);
        a2re_reg <= a1re_reg;
        a2im_reg <= a1im_reg;
        x_re     <= sat(sxr);
        x_im     <= sat(sxi);
        y_re     <= sat(syr);
        y_im     <= sat(syi);
    end

    always_comb begin
        rrr = (prr_reg + PB'(16384)) >>> 15;
        rii = (pii_reg + PB'(16384)) >>> 15;
        rri = (pri_reg + PB'(16384)) >>> 15;
        rir = (pir_reg + PB'(16384)) >>> 15;
        tr  = SB'(rrr) - SB'(rii);
        ti  = SB'(rri) + SB'(rir);
        sxr = SB'(a2re_reg) + tr;
        sxi = SB'(a2im_reg) + ti;
        syr = SB'(a2re_reg) - tr;
        syi = SB'(a2im_reg) - ti;
    end

endmodule : r2fft_bfly
`default_nettype wire

/* rtl/radix2_complex_fft.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// radix2_complex_fft
// In-place radix-2 decimation-in-time FFT over a pair of on-chip memories.
// ----------------------------------------------------------------------------
// Samples are written into the store at their arrival index, one per cycle
// while s_tready is high. On the N-th sample a bit-reversal pass reorders the
// store: an index that stays put is passed over, a swapped pair takes two
// reads and two writes. The block then runs log2(N) passes of N/2 butterflies
// each; every butterfly takes two memory reads, the 3-stage butterfly pipeline
// and two write-backs, set by the single read port and single write port of
// each memory, and the next butterfly starts only after both write-backs. The
// N bins then stream out in order, each read from the store only after the
// previous one is accepted, with the inverse scaling applied on the way out.
// Input and configuration writes are held off while a frame is reordered,
// transformed or read out.
module radix2_complex_fft
    import r2fft_pkg::*;
#(
    parameter int MAX_POINTS  = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int STORE_BITS  = 24
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // [SAMPLE_BITS-1:0] sample_re, [2*SAMPLE_BITS-1:SAMPLE_BITS] sample_im, zero pad
    input  wire  [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // [STORE_BITS-1:0] result_re, [2*STORE_BITS-1:STORE_BITS] result_im, zero pad
    output logic [((2*STORE_BITS+7)/8)*8-1:0] m_tdata,
    output logic                         m_tlast,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [0:0]                   cfg_index,
    input  wire  [2:0]                   cfg_data
);
    localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int LIM = (AW < ROM_LOG2) ? AW : ROM_LOG2;
    localparam int MDW = ((2*STORE_BITS+7)/8)*8;

    localparam logic [3:0] ST_LOAD = 4'd0;
    localparam logic [3:0] ST_RDA  = 4'd1;
    localparam logic [3:0] ST_RDB  = 4'd2;
    localparam logic [3:0] ST_WAIT = 4'd3;
    localparam logic [3:0] ST_OUT  = 4'd4;
    localparam logic [3:0] ST_SWA  = 4'd5;
    localparam logic [3:0] ST_SWB  = 4'd6;
    localparam logic [3:0] ST_SWX  = 4'd7;
    localparam logic [3:0] ST_SWY  = 4'd8;

    logic [3:0] state_reg;
    logic [2:0] lg_reg;
    logic       inv_reg;
    logic [AW:0] cnt_reg;          // load count, then reorder index, then bin counter
    logic [2:0] stage_reg;         // log2 of half span
    logic [AW-1:0] bf_reg;         // butterfly index within pass
    logic [2:0] pipe_reg;          // write-back countdown
    logic       rd_pend_reg;

    logic signed [STORE_BITS-1:0] mem_re [MAX_POINTS];
    logic signed [STORE_BITS-1:0] mem_im [MAX_POINTS];
    logic signed [STORE_BITS-1:0] rd_re_reg, rd_im_reg, a_re_reg, a_im_reg;
    logic signed [STORE_BITS-1:0] yh_re_reg, yh_im_reg;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wr_addr;
    logic signed [STORE_BITS-1:0] wr_re, wr_im;
    logic signed [STORE_BITS-1:0] out_re, out_im;

    logic [2:0] lg_eff;
    logic [AW:0] n_pts;
    logic [AW-1:0] pa_reg, pb_reg;
    logic [4:0] k_reg;
    logic signed [STORE_BITS-1:0] x_re, x_im, y_re, y_im;
    logic [AW-1:0] rev;
    logic [AW-1:0] pa, pb;
    logic [4:0] kk;

    assign lg_eff = (lg_reg > 3'(LIM)) ? 3'(LIM) : lg_reg;
    assign n_pts  = (AW+1)'(1) << lg_eff;
    assign cfg_ready = (state_reg == ST_LOAD);
    assign s_tready = (state_reg == ST_LOAD);

    // inverse scaling: arithmetic shift by log2 of the length
    assign out_re = inv_reg ? (rd_re_reg >>> lg_eff) : rd_re_reg;
    assign out_im = inv_reg ? (rd_im_reg >>> lg_eff) : rd_im_reg;

    always_comb begin
        rev = '0;
        for (int i = 0; i < AW; i++) begin
            if (i < lg_eff) rev[lg_eff - 1 - i] = cnt_reg[i];
        end
    end

    // butterfly addresses: insert a zero at bit 'stage' of bf, then top/bottom
    always_comb begin
        logic [AW-1:0] low_mask, lowp, highp, half;
        half     = AW'(1) << stage_reg;
        low_mask = half - AW'(1);
        lowp     = bf_reg & low_mask;
        highp    = (bf_reg & ~low_mask) << 1;
        pa = highp | lowp;
        pb = pa | half;
        kk = 5'((32'(lowp) << (5 - 32'(stage_reg))) & 32'd31);
    end

    always_comb begin
        we = 1'b0; wr_addr = '0; wr_re = '0; wr_im = '0;
        if (state_reg == ST_LOAD && s_tvalid) begin
            we = 1'b1; wr_addr = cnt_reg[AW-1:0];
            wr_re = STORE_BITS'($signed(s_tdata[SAMPLE_BITS-1:0]));
            wr_im = STORE_BITS'($signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
        end else if (state_reg == ST_SWX) begin
            we = 1'b1; wr_addr = cnt_reg[AW-1:0]; wr_re = rd_re_reg; wr_im = rd_im_reg;
        end else if (state_reg == ST_SWY) begin
            we = 1'b1; wr_addr = rev; wr_re = a_re_reg; wr_im = a_im_reg;
        end else if (pipe_reg == 3'd2) begin
            we = 1'b1; wr_addr = pa_reg; wr_re = x_re; wr_im = x_im;
        end else if (pipe_reg == 3'd1) begin
            we = 1'b1; wr_addr = pb_reg; wr_re = yh_re_reg; wr_im = yh_im_reg;
        end
    end

    always_comb begin
        unique case (state_reg)
            ST_RDA:  rd_addr = pa;
            ST_RDB:  rd_addr = pb;
            ST_SWB:  rd_addr = rev;
            default: rd_addr = cnt_reg[AW-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_re[wr_addr] <= wr_re;
            mem_im[wr_addr] <= wr_im;
        end
        rd_re_reg <= mem_re[rd_addr];
        rd_im_reg <= mem_im[rd_addr];
        if (state_reg == ST_RDB || state_reg == ST_SWB) begin
            a_re_reg <= rd_re_reg;
            a_im_reg <= rd_im_reg;
        end
        // butterfly outputs are valid for one cycle only; hold the lower one
        if (pipe_reg == 3'd2) begin
            yh_re_reg <= y_re;
            yh_im_reg <= y_im;
        end
    end

    r2fft_bfly #(.STORE_BITS(STORE_BITS)) u_bfly (
        .aclk(aclk), .twiddle_k(k_reg), .inverse(inv_reg),
        .a_re(a_re_reg), .a_im(a_im_reg), .b_re(rd_re_reg), .b_im(rd_im_reg),
        .x_re(x_re), .x_im(x_im), .y_re(y_re), .y_im(y_im)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD; lg_reg <= 3'd6; inv_reg <= 1'b0;
            cnt_reg <= '0; stage_reg <= '0; bf_reg <= '0; pipe_reg <= '0;
            rd_pend_reg <= 1'b0; m_tvalid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_LOG2_POINTS) lg_reg <= cfg_data;
                else inv_reg <= cfg_data[0];
            end
            if (pipe_reg != 3'd0) pipe_reg <= pipe_reg - 3'd1;
            unique case (state_reg)
                ST_LOAD: if (s_tvalid) begin
                    if (cnt_reg + 1'b1 >= n_pts) begin
                        cnt_reg <= '0; stage_reg <= '0; bf_reg <= '0;
                        if (lg_eff == 3'd0) state_reg <= ST_OUT;
                        else state_reg <= ST_SWA;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                // bit-reversal reorder: swap each pair once, lower index first
                ST_SWA: begin
                    if ((AW+1)'(rev) > cnt_reg) state_reg <= ST_SWB;
                    else if (cnt_reg + 1'b1 >= n_pts) begin
                        cnt_reg <= '0; state_reg <= ST_RDA;
                    end else cnt_reg <= cnt_reg + 1'b1;
                end
                ST_SWB: state_reg <= ST_SWX;
                ST_SWX: state_reg <= ST_SWY;
                ST_SWY: begin
                    if (cnt_reg + 1'b1 >= n_pts) begin
                        cnt_reg <= '0; state_reg <= ST_RDA;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1; state_reg <= ST_SWA;
                    end
                end
                ST_RDA: begin
                    pa_reg <= pa; pb_reg <= pb; k_reg <= kk;
                    state_reg <= ST_RDB;
                end
                ST_RDB: begin
                    state_reg <= ST_WAIT;
                    pipe_reg <= 3'd5;
                end
                ST_WAIT: if (pipe_reg == 3'd1) begin
                    if ((AW+1)'(bf_reg) + 1'b1 >= (n_pts >> 1)) begin
                        bf_reg <= '0;
                        if (stage_reg + 3'd1 >= lg_eff) state_reg <= ST_OUT;
                        else begin
                            stage_reg <= stage_reg + 3'd1; state_reg <= ST_RDA;
                        end
                    end else begin
                        bf_reg <= bf_reg + 1'b1; state_reg <= ST_RDA;
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid && !rd_pend_reg) begin
                        rd_pend_reg <= 1'b1;
                    end else if (rd_pend_reg) begin
                        rd_pend_reg <= 1'b0;
                        m_tvalid <= 1'b1;
                        m_tdata <= MDW'({out_im, out_re});
                        m_tlast <= (cnt_reg + 1'b1 == n_pts);
                    end else if (m_tready) begin
                        m_tvalid <= 1'b0;
                        if (m_tlast) begin
                            cnt_reg <= '0; state_reg <= ST_LOAD;
                        end else cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

endmodule : radix2_complex_fft
`default_nettype wire
